@@ rtl/assert_macros.svh @@
// Assertion macros shared by the display power controller RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DIDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DIDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dids_pkg.sv @@
// Types and constants for the display idle dim/sleep controller.
// No dependencies; used by the interfaces, the step logic and the top level.
package dids_pkg;

  localparam int unsigned TimeW = 32;

  localparam logic [TimeW-1:0] DimAfterRst = 32'd15000;
  localparam logic [TimeW-1:0] OffAfterRst = 32'd45000;

  typedef enum logic [1:0] {
    MODE_ACTIVE = 2'd0,
    MODE_DIMMED = 2'd1,
    MODE_OFF    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WAKE  = 2'd1,
    CMD_DIM   = 2'd2,
    CMD_SLEEP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_BUTTONS = 2'd1,
    REQ_RESTART = 2'd2
  } req_e;

  typedef enum logic {
    CFG_DIM_AFTER = 1'b0,
    CFG_OFF_AFTER = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [TimeW-1:0] now_ms;
    logic             pri_held;
    logic             sec_held;
    logic             pri_click;
    logic             pri_hold;
    logic             sec_click;
    logic             sec_hold;
  } req_t;

  typedef struct packed {
    logic [1:0] display_mode;
    logic [1:0] display_command;
    logic       out_pri_held;
    logic       out_sec_held;
    logic       out_pri_click;
    logic       out_pri_hold;
    logic       out_sec_click;
    logic       out_sec_hold;
  } res_t;

  typedef struct packed {
    mode_e            mode;
    logic [TimeW-1:0] last_ms;
    logic             suppress;
  } state_t;

  typedef struct packed {
    logic [TimeW-1:0] dim_after_ms;
    logic [TimeW-1:0] off_after_ms;
  } timeouts_t;

endpackage

@@ rtl/dids_req_if.sv @@
// Request channel: valid/ready handshake carrying one dids_pkg::req_t.
// Depends on dids_pkg.
interface dids_req_if;
  logic           valid;
  logic           ready;
  dids_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/dids_res_if.sv @@
// Result channel: valid/ready handshake carrying one dids_pkg::res_t.
// Depends on dids_pkg.
interface dids_res_if;
  logic           valid;
  logic           ready;
  dids_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/dids_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and write data.
// Depends on dids_pkg.
interface dids_cfg_if;
  logic                        valid;
  logic                        ready;
  logic                        index;
  logic [dids_pkg::TimeW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/dids_step.sv @@
// Next-state and result logic for one request of the display controller.
// Purely combinational; depends on dids_pkg.
module dids_step (
  input  dids_pkg::state_t    state_i,
  input  dids_pkg::req_t      req_i,
  input  dids_pkg::timeouts_t tmo_i,
  output dids_pkg::state_t    state_o,
  output dids_pkg::res_t      res_o
);

  logic [dids_pkg::TimeW-1:0] idle_ms;
  logic                       held;
  logic                       evt;
  logic                       pass;
  dids_pkg::cmd_e             cmd;

  assign idle_ms = req_i.now_ms - state_i.last_ms;
  assign held    = req_i.pri_held | req_i.sec_held;
  assign evt     = req_i.pri_click | req_i.pri_hold |
                   req_i.sec_click | req_i.sec_hold;

  always_comb begin
    state_o = state_i;
    cmd     = dids_pkg::CMD_NONE;
    pass    = 1'b0;
    unique case (dids_pkg::req_e'(req_i.req_type))
      dids_pkg::REQ_RESTART: begin
        state_o.suppress = 1'b0;
        state_o.mode     = dids_pkg::MODE_ACTIVE;
        state_o.last_ms  = req_i.now_ms;
        cmd              = dids_pkg::CMD_WAKE;
      end
      dids_pkg::REQ_TICK: begin
        // off timeout wins over dim timeout
        if (state_i.mode != dids_pkg::MODE_OFF) begin
          if (idle_ms >= tmo_i.off_after_ms) begin
            state_o.mode = dids_pkg::MODE_OFF;
            cmd          = dids_pkg::CMD_SLEEP;
          end else if (state_i.mode == dids_pkg::MODE_ACTIVE &&
                       idle_ms >= tmo_i.dim_after_ms) begin
            state_o.mode = dids_pkg::MODE_DIMMED;
            cmd          = dids_pkg::CMD_DIM;
          end
        end
      end
      dids_pkg::REQ_BUTTONS: begin
        if (state_i.suppress) begin
          // drop blanking once both buttons are released
          if (!held) begin
            state_o.suppress = 1'b0;
          end
        end else if (state_i.mode == dids_pkg::MODE_OFF) begin
          if (held || evt) begin
            state_o.mode     = dids_pkg::MODE_ACTIVE;
            state_o.last_ms  = req_i.now_ms;
            state_o.suppress = held;
            cmd              = dids_pkg::CMD_WAKE;
          end
        end else begin
          if (held || evt) begin
            state_o.last_ms = req_i.now_ms;
            if (state_i.mode != dids_pkg::MODE_ACTIVE) begin
              state_o.mode = dids_pkg::MODE_ACTIVE;
              cmd          = dids_pkg::CMD_WAKE;
            end
          end
          pass = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.display_mode    = state_o.mode;
    res_o.display_command = cmd;
    res_o.out_pri_held    = pass & req_i.pri_held;
    res_o.out_sec_held    = pass & req_i.sec_held;
    res_o.out_pri_click   = pass & req_i.pri_click;
    res_o.out_pri_hold    = pass & req_i.pri_hold;
    res_o.out_sec_click   = pass & req_i.sec_click;
    res_o.out_sec_hold    = pass & req_i.sec_hold;
  end

endmodule

@@ rtl/display_idle_dim_sleep_control.sv @@
// Display idle dim/sleep controller: power state machine for a display panel.
//
// Channels:
//   req_i  - request transfers: a time tick, a button sample or a restart,
//            each with a millisecond timestamp (wrapping at 32 bits).
//   res_o  - one result transfer per request: mode after the step, panel
//            command (none, wake, dim, sleep) and the filtered buttons.
//   cfg_i  - register writes: index 0 dim timeout, index 1 off timeout.
//            Always ready; write only while no request is in flight.
// Timing:
//   A request lands in the input register, runs through the step logic
//   (one 32-bit subtract and two compares) and then lands in the result register,
//   from which its result transfers.
//   The state update closes within that one step, so one request per cycle while res_o does not stall.
// Reset:
//   Mode active, last activity zero, blanking clear, timeouts 15000/45000 ms.
// Backpressure:
//   When res_o stalls, the result register holds; the input register keeps
//   taking one more request, then req_i.ready drops until the result moves.
// Depends on dids_pkg, the channel interfaces, dids_step and assert_macros.svh.
`include "assert_macros.svh"

module display_idle_dim_sleep_control (
  input  logic       clk_i,
  input  logic       rst_ni,
  dids_req_if.sink   req_i,
  dids_res_if.source res_o,
  dids_cfg_if.sink   cfg_i
);

  logic                in_vld_q;
  dids_pkg::req_t      in_q;
  logic                out_vld_q;
  dids_pkg::res_t      out_q;
  dids_pkg::state_t    state_q;
  dids_pkg::state_t    state_d;
  dids_pkg::res_t      res_d;
  dids_pkg::timeouts_t tmo_q;
  logic                out_free;
  logic                adv;

  // Result register is free when empty or being taken this cycle.
  assign out_free    = !out_vld_q || res_o.ready;
  // Advance the input register into the result register.
  assign adv         = in_vld_q && out_free;
  assign req_i.ready = !in_vld_q || out_free;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid   = out_vld_q;
  assign res_o.payload = out_q;

  dids_step u_step (
    .state_i (state_q),
    .req_i   (in_q),
    .tmo_i   (tmo_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Input register: capture a request whenever the slot is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.payload;
    end
  end

  // Result register and power state advance together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q        <= 1'b0;
      state_q.mode     <= dids_pkg::MODE_ACTIVE;
      state_q.last_ms  <= '0;
      state_q.suppress <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  // Timeout registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q.dim_after_ms <= dids_pkg::DimAfterRst;
      tmo_q.off_after_ms <= dids_pkg::OffAfterRst;
    end else if (cfg_i.valid) begin
      unique case (dids_pkg::cfg_reg_e'(cfg_i.index))
        dids_pkg::CFG_DIM_AFTER: tmo_q.dim_after_ms <= cfg_i.data;
        dids_pkg::CFG_OFF_AFTER: tmo_q.off_after_ms <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // A sleep command leaves the display off.
  `DIDS_ASSERT_IMP(a_sleep_off,
    out_vld_q && out_q.display_command == dids_pkg::CMD_SLEEP,
    out_q.display_mode == dids_pkg::MODE_OFF, "sleep command without off mode")

  // A wake command always lands in active mode.
  `DIDS_ASSERT_IMP(a_wake_active,
    out_vld_q && out_q.display_command == dids_pkg::CMD_WAKE,
    out_q.display_mode == dids_pkg::MODE_ACTIVE, "wake command without active mode")

  // Buttons never pass through while the display is off.
  `DIDS_ASSERT_IMP(a_blank_off,
    out_vld_q && out_q.display_mode == dids_pkg::MODE_OFF,
    !(out_q.out_pri_held || out_q.out_sec_held ||
      out_q.out_pri_click || out_q.out_pri_hold ||
      out_q.out_sec_click || out_q.out_sec_hold),
    "buttons passed while off")

  // Power state only moves when a request advances.
  `DIDS_ASSERT_NXT(a_state_hold, !adv, $stable(state_q), "state changed without a request")

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for display_idle_dim_sleep_control.
// Depends on dids_pkg and the dids_req_if, dids_res_if and dids_cfg_if channel interfaces.
// Runs directed power-state sequences, then random phases under varied timeouts.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code that the block must ignore (no member of req_e).
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  // Button field masks in req_t order: held flags, then click/hold events.
  localparam logic [5:0] BTN_NONE      = 6'b000000;
  localparam logic [5:0] BTN_PRI_HELD  = 6'b100000;
  localparam logic [5:0] BTN_SEC_HELD  = 6'b010000;
  localparam logic [5:0] BTN_PRI_SHORT = 6'b001000;
  localparam logic [5:0] BTN_PRI_LONG  = 6'b000100;
  localparam logic [5:0] BTN_SEC_SHORT = 6'b000010;
  localparam logic [5:0] BTN_SEC_LONG  = 6'b000001;
  localparam logic [5:0] BTN_ALL       = 6'b111111;

  localparam logic [31:0] MS_MAX = 32'hFFFF_FFFF;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum int unsigned {RX_ALWAYS, RX_LIGHT, RX_HEAVY} rx_mode_e;

  logic clk_i;
  logic rst_ni;

  dids_req_if req_ch ();
  dids_res_if res_ch ();
  dids_cfg_if cfg_ch ();

  display_idle_dim_sleep_control uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // Power-state predictor: its own copy of state and timeouts.
  dids_pkg::mode_e disp_mode;
  logic [31:0]     last_activity_ms;
  logic            blanking;
  logic [31:0]     dim_limit_ms;
  logic [31:0]     off_limit_ms;

  // Results still owed by the block, oldest first.
  dids_pkg::res_t  expected_results[$];

  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned sent_count;

  // Sender burst shaping and receiver stall pattern.
  int unsigned burst_left;
  bit          gaps_on;
  rx_mode_e    rx_mode;
  int unsigned stall_left;

  // Running millisecond clock for the stimulus.
  logic [31:0] ms_cursor;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Run-length watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Work out the result of one request and advance the predicted state.
  function automatic dids_pkg::res_t power_step(input dids_pkg::req_t r);
    dids_pkg::res_t o;
    logic           held;
    logic           evt;
    logic           pass;
    logic [31:0]    idle_ms;
    dids_pkg::cmd_e cmd;
    cmd     = dids_pkg::CMD_NONE;
    pass    = 1'b0;
    held    = r.pri_held | r.sec_held;
    evt     = r.pri_click | r.pri_hold | r.sec_click | r.sec_hold;
    idle_ms = r.now_ms - last_activity_ms;
    case (r.req_type)
      dids_pkg::REQ_RESTART: begin
        blanking         = 1'b0;
        disp_mode        = dids_pkg::MODE_ACTIVE;
        last_activity_ms = r.now_ms;
        cmd              = dids_pkg::CMD_WAKE;
      end
      dids_pkg::REQ_TICK: begin
        // Off timeout wins over the dim timeout.
        if (disp_mode != dids_pkg::MODE_OFF) begin
          if (idle_ms >= off_limit_ms) begin
            disp_mode = dids_pkg::MODE_OFF;
            cmd       = dids_pkg::CMD_SLEEP;
          end else if (disp_mode == dids_pkg::MODE_ACTIVE && idle_ms >= dim_limit_ms) begin
            disp_mode = dids_pkg::MODE_DIMMED;
            cmd       = dids_pkg::CMD_DIM;
          end
        end
      end
      dids_pkg::REQ_BUTTONS: begin
        if (blanking) begin
          // Blanked until both buttons are up.
          if (!held) blanking = 1'b0;
        end else if (disp_mode == dids_pkg::MODE_OFF) begin
          // Wake gesture is swallowed; keep blanking while it is held.
          if (held || evt) begin
            disp_mode        = dids_pkg::MODE_ACTIVE;
            last_activity_ms = r.now_ms;
            cmd              = dids_pkg::CMD_WAKE;
            blanking         = held;
          end
        end else begin
          if (held || evt) begin
            if (disp_mode != dids_pkg::MODE_ACTIVE) cmd = dids_pkg::CMD_WAKE;
            disp_mode        = dids_pkg::MODE_ACTIVE;
            last_activity_ms = r.now_ms;
          end
          pass = 1'b1;
        end
      end
      default: begin
      end
    endcase
    o.display_mode    = disp_mode;
    o.display_command = cmd;
    o.out_pri_held    = pass & r.pri_held;
    o.out_sec_held    = pass & r.sec_held;
    o.out_pri_click   = pass & r.pri_click;
    o.out_pri_hold    = pass & r.pri_hold;
    o.out_sec_click   = pass & r.sec_click;
    o.out_sec_hold    = pass & r.sec_hold;
    return o;
  endfunction

  function automatic dids_pkg::req_t make_req(input logic [1:0] kind,
                                              input logic [31:0] t,
                                              input logic [5:0] btn);
    return {kind, t, btn};
  endfunction

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Offer one request, hold it until the transfer, then record its result.
  // After each burst the sender may drop valid for a random gap.
  task automatic send_req(input dids_pkg::req_t r);
    int unsigned gap;
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    expected_results.push_back(power_step(r));
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 19);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Write both timeouts back to back while the block is idle.
  task automatic set_timeouts(input logic [31:0] dim, input logic [31:0] off);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= dids_pkg::CFG_DIM_AFTER;
    cfg_ch.data  <= dim;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    dim_limit_ms = dim;
    cfg_ch.index <= dids_pkg::CFG_OFF_AFTER;
    cfg_ch.data  <= off;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    off_limit_ms = off;
    cfg_ch.valid <= 1'b0;
  endtask

  // Receiver: always ready, or stalls of random length at light or heavy rate.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (rx_mode == RX_ALWAYS) begin
      res_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 99) < ((rx_mode == RX_HEAVY) ? 50 : 20)) begin
      res_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, (rx_mode == RX_HEAVY) ? 11 : 3);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk_i) begin : check_result
    dids_pkg::res_t got;
    dids_pkg::res_t want;
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got = res_ch.payload;
      if (expected_results.size() == 0) begin
        report_error($sformatf("result with nothing owed: mode=%0d cmd=%0d btn=%06b",
                               got.display_mode, got.display_command, got[5:0]));
      end else begin
        want = expected_results.pop_front();
        if (got.display_mode    !== want.display_mode    ||
            got.display_command !== want.display_command ||
            got.out_pri_held    !== want.out_pri_held    ||
            got.out_sec_held    !== want.out_sec_held    ||
            got.out_pri_click   !== want.out_pri_click   ||
            got.out_pri_hold    !== want.out_pri_hold    ||
            got.out_sec_click   !== want.out_sec_click   ||
            got.out_sec_hold    !== want.out_sec_hold) begin
          report_error($sformatf(
            "expected mode=%0d cmd=%0d btn=%06b, got mode=%0d cmd=%0d btn=%06b",
            want.display_mode, want.display_command, want[5:0],
            got.display_mode, got.display_command, got[5:0]));
        end
      end
    end
  end

  // Walk the power states with the reset timeouts (15000 / 45000 ms).
  task automatic test_power_states();
    send_req(make_req(dids_pkg::REQ_TICK, 32'd0, BTN_NONE));
    // tick: buttons never pass
    send_req(make_req(dids_pkg::REQ_TICK, 32'd14999, BTN_ALL));
    send_req(make_req(dids_pkg::REQ_TICK, 32'd15000, BTN_NONE));     // dim
    send_req(make_req(dids_pkg::REQ_TICK, 32'd44999, BTN_NONE));
    send_req(make_req(dids_pkg::REQ_TICK, 32'd45000, BTN_NONE));     // sleep
    // tick while off: no change
    send_req(make_req(dids_pkg::REQ_TICK, MS_MAX, BTN_NONE));
    // Wake by holding a button: swallowed, blanked until release.
    send_req(make_req(dids_pkg::REQ_BUTTONS, 32'd46000, BTN_PRI_HELD));
    send_req(make_req(dids_pkg::REQ_BUTTONS, 32'd46010,
                      BTN_SEC_HELD | BTN_PRI_SHORT | BTN_SEC_LONG));
    // release clears blanking
    send_req(make_req(dids_pkg::REQ_BUTTONS, 32'd46020, BTN_NONE));
    // active: pass through
    send_req(make_req(dids_pkg::REQ_BUTTONS, 32'd46030, BTN_ALL));
    send_req(make_req(REQ_UNKNOWN, 32'd46040, BTN_ALL));   // ignored request
    // Restart near the top of the clock, then go straight off across the wrap.
    send_req(make_req(dids_pkg::REQ_RESTART, 32'hFFFF_FFF0, BTN_ALL));
    send_req(make_req(dids_pkg::REQ_TICK, 32'd44984, BTN_NONE));
    // Wake by event only: no blanking afterwards.
    send_req(make_req(dids_pkg::REQ_BUTTONS, 32'd50000, BTN_PRI_LONG));
    send_req(make_req(dids_pkg::REQ_TICK, 32'd65000, BTN_NONE));     // dim
    // wake from dim, passed
    send_req(make_req(dids_pkg::REQ_BUTTONS, 32'd65001, BTN_SEC_SHORT));
    // no activity refresh
    send_req(make_req(dids_pkg::REQ_BUTTONS, 32'd65002, BTN_NONE));
    send_req(make_req(dids_pkg::REQ_TICK, 32'd110001, BTN_NONE));    // sleep
    // quiet sample while off
    send_req(make_req(dids_pkg::REQ_BUTTONS, 32'd110002, BTN_NONE));
    send_req(make_req(dids_pkg::REQ_RESTART, 32'd0, BTN_NONE));
  endtask

  // Extreme timeouts: full-range, zero, and dim before off by one.
  task automatic test_timeout_extremes();
    set_timeouts(MS_MAX, MS_MAX);
    send_req(make_req(dids_pkg::REQ_RESTART, 32'd5, BTN_NONE));
    // one short of the limit
    send_req(make_req(dids_pkg::REQ_TICK, 32'd3, BTN_NONE));
    // idle is the full range
    send_req(make_req(dids_pkg::REQ_TICK, 32'd4, BTN_NONE));
    send_req(make_req(dids_pkg::REQ_BUTTONS, 32'd100, BTN_PRI_HELD | BTN_SEC_HELD));
    send_req(make_req(dids_pkg::REQ_BUTTONS, 32'd101, BTN_NONE));
    set_timeouts(32'd0, 32'd0);
    // zero timeouts: sleeps at an idle of 1 ms
    send_req(make_req(dids_pkg::REQ_TICK, 32'd101, BTN_NONE));
    send_req(make_req(dids_pkg::REQ_TICK, 32'd0, BTN_NONE));
    set_timeouts(32'd0, 32'd1);
    send_req(make_req(dids_pkg::REQ_RESTART, 32'd7, BTN_NONE));
    send_req(make_req(dids_pkg::REQ_TICK, 32'd7, BTN_NONE));         // dim at zero idle
    send_req(make_req(dids_pkg::REQ_TICK, 32'd8, BTN_NONE));         // then off
  endtask

  // Random phases: each sets timeouts, idling style and time step, then mixes
  // ticks, press-hold-release gestures, restarts and noise.
  task automatic test_random_phases();
    int unsigned pick;
    int unsigned n;
    int unsigned ev;
    int unsigned inc_max;
    int unsigned phase_end;
    logic [31:0] dim;
    logic [31:0] off;
    logic [5:0]  btn;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin dim = 32'd15000; off = 32'd45000; inc_max = 7000; end
        1: begin dim = 32'd50;    off = 32'd150;   inc_max = 40;   end
        2: begin dim = 32'd150;   off = 32'd50;    inc_max = 40;   end
        3: begin dim = 32'd0;     off = 32'd0;     inc_max = 10;   end
        4: begin dim = MS_MAX;    off = MS_MAX;    inc_max = 3000; end
        5: begin
          dim = $urandom_range(0, 200);
          off = $urandom_range(0, 400);
          inc_max = 80;
        end
        default: begin dim = $urandom(); off = $urandom(); inc_max = MS_MAX; end
      endcase
      set_timeouts(dim, off);
      rx_mode   = rx_mode_e'(ph % 3);
      gaps_on   = (ph % 4 != 3);
      ms_cursor = $urandom();
      phase_end = sent_count + 160;
      while (sent_count < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          ms_cursor += $urandom_range(0, inc_max);
          send_req(make_req(dids_pkg::REQ_TICK, ms_cursor, 6'($urandom_range(0, 63))));
        end else if (pick < 70) begin
          // Hold one or both buttons for a few samples, then release, with or without an event.
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) begin
            btn = {2'($urandom_range(1, 3)), 4'b0000};
            if ($urandom_range(0, 3) == 0) btn |= BTN_PRI_LONG;
            ms_cursor += $urandom_range(0, inc_max / 8 + 1);
            send_req(make_req(dids_pkg::REQ_BUTTONS, ms_cursor, btn));
          end
          ev  = $urandom_range(0, 4);
          btn = (ev == 0) ? BTN_NONE : (BTN_SEC_LONG << (ev - 1));
          ms_cursor += $urandom_range(0, inc_max / 8 + 1);
          send_req(make_req(dids_pkg::REQ_BUTTONS, ms_cursor, btn));
        end else if (pick < 80) begin
          ms_cursor += $urandom_range(0, inc_max);
          send_req(make_req(dids_pkg::REQ_BUTTONS, ms_cursor,
                            6'($urandom_range(0, 63))));
        end else if (pick < 88) begin
          ms_cursor += $urandom_range(0, inc_max);
          send_req(make_req(dids_pkg::REQ_RESTART, ms_cursor,
                            6'($urandom_range(0, 63))));
        end else if (pick < 92) begin
          send_req(make_req(REQ_UNKNOWN, $urandom(), 6'($urandom_range(0, 63))));
        end else begin
          // Jump anywhere on the 32-bit clock.
          ms_cursor = $urandom();
          send_req(make_req(dids_pkg::REQ_TICK, ms_cursor, BTN_NONE));
        end
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    res_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = dids_pkg::CFG_DIM_AFTER;
    cfg_ch.data    = '0;
    err_count      = 0;
    cycle_count    = 0;
    sent_count     = 0;
    burst_left     = 0;
    stall_left     = 0;
    gaps_on        = 1'b1;
    rx_mode        = RX_LIGHT;
    ms_cursor      = '0;
    // Predictor starts from the reset state.
    disp_mode        = dids_pkg::MODE_ACTIVE;
    last_activity_ms = '0;
    blanking         = 1'b0;
    dim_limit_ms     = dids_pkg::DimAfterRst;
    off_limit_ms     = dids_pkg::OffAfterRst;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_states();
    test_timeout_extremes();
    test_random_phases();

    // Drain, then keep watching for stray results.
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ display_idle_dim_sleep_control.f @@
+incdir+rtl
rtl/dids_pkg.sv
rtl/dids_req_if.sv
rtl/dids_res_if.sv
rtl/dids_cfg_if.sv
rtl/dids_step.sv
rtl/display_idle_dim_sleep_control.sv
tb/sv/testbench.sv
